// ===== sv/bppc_pkg.sv =====
// ----------------------------------------------------------------------------
// bppc_pkg: shared types and constants for the bounded-part partition counter
// Table geometry, count width, cell addressing and the controller command and
// status bundles.
// ----------------------------------------------------------------------------
package bppc_pkg;

   localparam int TABLE_SIDE = 64;
   localparam int FIELD_W    = 6;
   localparam int COUNT_W    = 21;
   localparam int IDX_W      = $clog2(TABLE_SIDE);
   localparam int DEPTH      = TABLE_SIDE * TABLE_SIDE;
   localparam int ADDR_W     = $clog2(DEPTH);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [FIELD_W-1:0] field_type;

   typedef struct packed {
      logic load;
      logic calc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_cell;
   } status_type;

   function automatic idx_type clamp_side(input field_type v);
      if (int'(v) > TABLE_SIDE - 1) begin
         return IDX_W'(TABLE_SIDE - 1);
      end
      return IDX_W'(v);
   endfunction

   function automatic addr_type cell_addr(input idx_type row, input idx_type col);
      return ADDR_W'(row) * ADDR_W'(TABLE_SIDE) + ADDR_W'(col);
   endfunction

endpackage

// ===== sv/bppc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bppc_ctrl: sequencer for the table fill
// Accepts a query, steps the datapath through read and update of each cell,
// and hands the finished count to the output register.
// ----------------------------------------------------------------------------
module bppc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bppc_pkg::cmd_type    cmd,
   input  bppc_pkg::status_type status
);
   import bppc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, rsp_valid_ff, rsp_valid_in;
   logic      take_req, take_rsp;

   // the final cell value is ready in the cycle after calc; emit from IDLE entry
   logic emit_ff, emit_in;

   assign take_req  = req_valid && req_ready_ff;
   assign take_rsp  = rsp_valid_ff && rsp_ready;
   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = take_req;
      cmd.emit = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_req) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            if (!status.last_cell) begin
               state_in = ST_READ;
            end else if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign emit_in  = (state_ff == ST_CALC && status.last_cell && (!rsp_valid_ff || rsp_ready))
                  || (state_ff == ST_HOLD && rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take_rsp) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         emit_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE) && !emit_in;
         rsp_valid_ff <= rsp_valid_in;
         emit_ff      <= emit_in;
      end
   end

endmodule

// ===== sv/bppc_datapath.sv =====
// ----------------------------------------------------------------------------
// bppc_datapath: working table, cell counters and saturating adder
// Holds the row and column counters, the table memory, the running cell value
// and the output count register.
// ----------------------------------------------------------------------------
module bppc_datapath (
   input  logic                   clock,
   input  logic [5:0]             req_amount,
   input  logic [5:0]             req_part_limit,
   input  bppc_pkg::cmd_type      cmd,
   output bppc_pkg::status_type   status,
   output logic [20:0]            rsp_count
);
   import bppc_pkg::*;

   count_type table_mem [DEPTH];

   idx_type   amt_ff, lim_ff, m_ff, j_ff;
   idx_type   m_in, j_in, up_row;
   count_type rd_ff, prev_ff, cell_in, count_ff;
   logic [COUNT_W:0] sum;

   assign status.last_cell = (m_ff == amt_ff) && (j_ff == lim_ff);
   assign up_row           = (m_ff >= j_ff) ? m_ff - j_ff : '0;
   assign sum              = {1'b0, rd_ff} + {1'b0, prev_ff};

   always_comb begin
      if (j_ff == '0) begin
         cell_in = '0;
      end else if (m_ff == '0) begin
         cell_in = count_type'(1);
      end else if (m_ff < j_ff) begin
         cell_in = prev_ff;
      end else if (sum[COUNT_W]) begin
         cell_in = COUNT_MAX;
      end else begin
         cell_in = sum[COUNT_W-1:0];
      end
   end

   always_comb begin
      m_in = m_ff;
      j_in = j_ff;
      if (j_ff == lim_ff) begin
         j_in = '0;
         m_in = m_ff + idx_type'(1);
      end else begin
         j_in = j_ff + idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= table_mem[cell_addr(up_row, j_ff)];
      if (cmd.calc) begin
         table_mem[cell_addr(m_ff, j_ff)] <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         amt_ff <= clamp_side(req_amount);
         lim_ff <= clamp_side(req_part_limit);
         m_ff   <= '0;
         j_ff   <= '0;
      end else if (cmd.calc) begin
         m_ff    <= m_in;
         j_ff    <= j_in;
         prev_ff <= cell_in;
      end
      if (cmd.emit) begin
         count_ff <= prev_ff;
      end
   end

   assign rsp_count = count_ff;

endmodule

// ===== sv/bounded_part_partition_count.sv =====
// ----------------------------------------------------------------------------
// bounded_part_partition_count: partitions of an amount with bounded parts
// Fills a working table bottom-up, one cell per read and calc step, and returns the
// entry for the requested amount and part limit.
// ----------------------------------------------------------------------------
// Operands are clamped to the table side. One query is handled at a time; each
// cell takes a table read and a write to the table memory.
// Reset clears the controller only; the table needs no clearing pass.
module bounded_part_partition_count (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [5:0]  req_amount,
   input  logic [5:0]  req_part_limit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_count
);
   import bppc_pkg::*;

   cmd_type    cmd;
   status_type status;

   bppc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   bppc_datapath u_datapath (
      .clock          (clock),
      .req_amount     (req_amount),
      .req_part_limit (req_part_limit),
      .cmd            (cmd),
      .status         (status),
      .rsp_count      (rsp_count)
   );

endmodule

// ===== tb/tb_bounded_part_partition_count.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_part_partition_count: self-checking bench for the partition counter
// Sends a table of directed queries and then random ones, mostly small, over
// three pacing phases with random request gaps and response stalls. Each count
// is compared with a local table-fill predictor or with a value typed in.
// ----------------------------------------------------------------------------
module tb_bounded_part_partition_count;
   import bppc_pkg::*;

   localparam int RANDOM_QUERIES = 116;
   localparam int DIRECTED_ROWS  = 24;

   typedef struct packed {
      field_type amount;
      field_type limit;
      logic      known;
      count_type count;
   } query_row_type;

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      req_valid      = 1'b0;
   logic      req_ready;
   field_type req_amount     = '0;
   field_type req_part_limit = '0;
   logic      rsp_valid;
   logic      rsp_ready      = 1'b0;
   count_type rsp_count;

   count_type pending_counts[$];
   count_type partial_sums [0:TABLE_SIDE-1][0:TABLE_SIDE-1];
   int        failures           = 0;
   int        counts_checked     = 0;
   int        queries_sent       = 0;
   int        sender_idle_pct    = 8;
   int        receiver_stall_pct = 51;

   query_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{6'd0,  6'd0,  1'b1, 21'd0},
      '{6'd63, 6'd0,  1'b1, 21'd0},
      '{6'd1,  6'd0,  1'b1, 21'd0},
      '{6'd0,  6'd1,  1'b1, 21'd1},
      '{6'd0,  6'd63, 1'b1, 21'd1},
      '{6'd1,  6'd1,  1'b1, 21'd1},
      '{6'd1,  6'd63, 1'b1, 21'd1},
      '{6'd2,  6'd63, 1'b1, 21'd2},
      '{6'd63, 6'd1,  1'b1, 21'd1},
      '{6'd63, 6'd2,  1'b1, 21'd32},
      '{6'd5,  6'd5,  1'b1, 21'd7},
      '{6'd10, 6'd63, 1'b1, 21'd42},
      '{6'd20, 6'd20, 1'b1, 21'd627},
      '{6'd30, 6'd30, 1'b1, 21'd5604},
      '{6'd63, 6'd63, 1'b1, 21'd1505499},
      '{6'd63, 6'd62, 1'b1, 21'd1505498},
      '{6'd42, 6'd21, 1'b0, 21'd0},
      '{6'd21, 6'd42, 1'b0, 21'd0},
      '{6'd7,  6'd3,  1'b0, 21'd0},
      '{6'd3,  6'd7,  1'b0, 21'd0},
      '{6'd12, 6'd5,  1'b0, 21'd0},
      '{6'd48, 6'd16, 1'b0, 21'd0},
      '{6'd62, 6'd61, 1'b0, 21'd0},
      '{6'd33, 6'd63, 1'b0, 21'd0}
   };

   bounded_part_partition_count dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_amount     (req_amount),
      .req_part_limit (req_part_limit),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_count      (rsp_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic count_type bounded_partitions(input field_type amount,
                                                    input field_type limit);
      int               rows;
      int               cols;
      logic [COUNT_W:0] sum;
      rows = (int'(amount) > TABLE_SIDE - 1) ? TABLE_SIDE - 1 : int'(amount);
      cols = (int'(limit) > TABLE_SIDE - 1) ? TABLE_SIDE - 1 : int'(limit);
      for (int m = 0; m <= rows; m++) begin
         for (int j = 0; j <= cols; j++) begin
            if (j == 0) begin
               partial_sums[m][j] = '0;
            end else if (m == 0) begin
               partial_sums[m][j] = count_type'(1);
            end else if (m < j) begin
               partial_sums[m][j] = partial_sums[m][m];
            end else begin
               sum = {1'b0, partial_sums[m-j][j]} + {1'b0, partial_sums[m][j-1]};
               partial_sums[m][j] = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                             : sum[COUNT_W-1:0];
            end
         end
      end
      return partial_sums[rows][cols];
   endfunction

   task automatic send_query(input field_type amount, input field_type limit,
                             input logic known, input count_type typed_count);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_amount     <= amount;
      req_part_limit <= limit;
      do @(posedge clock); while (!req_ready);
      pending_counts.push_back(known ? typed_count : bounded_partitions(amount, limit));
      queries_sent++;
   endtask

   task automatic drain_counts();
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            $error("count transfer with no query pending: actual %0d", rsp_count);
            failures++;
         end else begin
            if (rsp_count !== pending_counts[0]) begin
               $error("count mismatch: expected %0d, actual %0d",
                      pending_counts[0], rsp_count);
               failures++;
            end
            void'(pending_counts.pop_front());
            counts_checked++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   initial begin
      field_type amount;
      field_type limit;
      int        kind;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_query(directed_rows[i].amount, directed_rows[i].limit,
                    directed_rows[i].known, directed_rows[i].count);
      end

      for (int n = 0; n < RANDOM_QUERIES; n++) begin
         if (n == RANDOM_QUERIES / 3) begin
            drain_counts();
            sender_idle_pct    = 51;
            receiver_stall_pct = 8;
         end else if (n == 2 * RANDOM_QUERIES / 3) begin
            drain_counts();
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         kind = $urandom_range(99);
         if (kind < 80) begin
            amount = field_type'($urandom_range(12));
            limit  = field_type'($urandom_range(14));
         end else if (kind < 93) begin
            amount = field_type'($urandom_range(63));
            limit  = field_type'($urandom_range(63));
         end else begin
            amount = $urandom_range(1) ? field_type'(63) : field_type'(0);
            limit  = field_type'($urandom_range(63));
         end
         send_query(amount, limit, 1'b0, '0);
      end

      drain_counts();
      repeat (16) @(posedge clock);
      $display("covered %0d queries (%0d directed, %0d random) in three pacing phases",
               queries_sent, DIRECTED_ROWS, RANDOM_QUERIES);
      $display("checked %0d counts, %0d mismatches or unexpected transfers",
               counts_checked, failures);
      if (failures == 0) begin
         $display("bounded_part_partition_count regression: pass");
      end else begin
         $display("bounded_part_partition_count regression: fail");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("bounded_part_partition_count regression: fail");
      $finish;
   end

endmodule
